// ----- design/srt_pkg.sv -----
// Shared widths, constants, types and the arctangent table of the scale/rotate/translate unit.
package srt_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int GAIN_W    = 24;
    localparam int ANG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Parameter defaults
    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int ATAN_COUNT        = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y        = 3'd5;

    // Gain reset is 1.0 in Q8.16
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sd65536;

    // Scaled coordinates: 16 fraction bits in 40 signed bits
    localparam int SCALED_W = 40;
    localparam logic signed [SCALED_W-1:0] SCALED_MAX = {1'b0, {(SCALED_W-1){1'b1}}};
    localparam logic signed [SCALED_W-1:0] SCALED_MIN = {1'b1, {(SCALED_W-1){1'b0}}};

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // CORDIC datapath: 30 fraction bits, sine/cosine kept with 22
    localparam int CORDIC_W    = 32;
    localparam int CORDIC_FRAC = 30;
    localparam int TRIG_FRAC   = 22;
    localparam int TRIG_SHIFT  = CORDIC_FRAC - TRIG_FRAC;
    localparam int TRIG_W      = CORDIC_W - TRIG_SHIFT;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 32'sd652032874;
    localparam logic signed [TRIG_W-1:0]   TRIG_ONE = 24'sd4194304;

    // Angle to binary angle: b = floor((a * 2^22 + 22) / 45)
    //   = a * 93206 + floor((34 * a + 22) / 45), since 2^22 = 45 * 93206 + 34
    localparam logic [ANG_W-1:0] ANGLE_TURN = 16'd46080;
    localparam int BANG_W          = 32;
    localparam int V_W             = 21;
    localparam int ANG_V_MUL       = 34;
    localparam int ANG_V_ADD       = 22;
    localparam int ANG_BASE_MUL    = 93206;
    localparam int ANG_DIV         = 45;
    localparam int ANG_RECIP       = 2982616;   // floor(2^27 / 45)
    localparam int ANG_RECIP_W     = 22;
    localparam int ANG_RECIP_SHIFT = 27;
    localparam int MQ_W            = V_W + ANG_RECIP_W;
    localparam int Q_W             = MQ_W - ANG_RECIP_SHIFT;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic                      parent_enable;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic [ANG_W-1:0]          angle;
        logic signed [GAIN_W-1:0]  gain_x;
        logic signed [GAIN_W-1:0]  gain_y;
    } cfg_t;

    // Scaled point and its clamp flag
    typedef struct packed {
        logic signed [SCALED_W-1:0] sx;
        logic signed [SCALED_W-1:0] sy;
        logic                       sat;
    } scl_t;

    // Beat handed from cell to cell
    typedef struct packed {
        scl_t                       scl;
        logic                       flip;
        logic signed [CORDIC_W-1:0] cx;
        logic signed [CORDIC_W-1:0] cy;
        logic signed [CORDIC_W-1:0] cz;
    } cell_t;

    // atan(2^-i) in binary angle units (2^32 per turn)
    function automatic logic [CORDIC_W-1:0] atan_turn(input int idx);
        logic [CORDIC_W-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/srt_front.sv -----
// Front pipeline: per-axis scaling and conversion of the angle to a folded CORDIC start.
module srt_front
    import srt_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_vld,
    output logic                      in_rdy,
    input  logic signed [COORD_W-1:0] lx,
    input  logic signed [COORD_W-1:0] ly,
    output logic                      out_vld,
    input  logic                      out_rdy,
    output cell_t                     out_data
);

    localparam int NST  = 5;
    // two extra bits so a unity gain fits at the widest fraction
    localparam int EG_W = GAIN_W + 2;
    localparam int PW   = COORD_W + EG_W;
    localparam logic signed [EG_W-1:0] UNITY_GAIN = {{(EG_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [PW:0]     HALF       = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [PW:0]     SMAX       = (PW + 1)'(SCALED_MAX);
    localparam logic signed [PW:0]     SMIN       = (PW + 1)'(SCALED_MIN);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] go;

    // stage 0
    logic signed [EG_W-1:0]  gx_eff;
    logic signed [EG_W-1:0]  gy_eff;
    logic signed [PW-1:0]    s0_prodx_reg, s0_prodx_next;
    logic signed [PW-1:0]    s0_prody_reg, s0_prody_next;
    logic [ANG_W-1:0]        s0_aw_reg, s0_aw_next;
    // stage 1
    logic signed [PW:0]      rx, ry, shx, shy;
    scl_t                    s1_scl_reg, s1_scl_next;
    logic [V_W-1:0]          s1_v_reg, s1_v_next;
    logic [BANG_W-1:0]       s1_base_reg, s1_base_next;
    // stage 2
    logic [MQ_W-1:0]         mq;
    scl_t                    s2_scl_reg;
    logic [V_W-1:0]          s2_v_reg;
    logic [BANG_W-1:0]       s2_base_reg;
    logic [Q_W-1:0]          s2_q0_reg, s2_q0_next;
    // stage 3
    logic [V_W-1:0]          rem;
    scl_t                    s3_scl_reg;
    logic [BANG_W-1:0]       s3_base_reg;
    logic [Q_W-1:0]          s3_q_reg, s3_q_next;
    // stage 4
    logic [BANG_W-1:0]       bsum, bfold;
    logic                    fold;
    cell_t                   s4_cell_reg, s4_cell_next;

    // Stall chain: a stage loads when empty or when the next one moves
    always_comb
    begin
        go[NST-1] = !vld_reg[NST-1] || out_rdy;
        for (int i = NST - 2; i >= 0; i--)
        begin
            go[i] = !vld_reg[i] || go[i+1];
        end
        vld_next[0] = go[0] ? in_vld : vld_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            vld_next[i] = go[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 0: products; pass mode uses a unity gain so the point survives unchanged
    always_comb
    begin
        gx_eff        = cfg.parent_enable ? {{2{cfg.gain_x[GAIN_W-1]}}, cfg.gain_x}
                                          : UNITY_GAIN;
        gy_eff        = cfg.parent_enable ? {{2{cfg.gain_y[GAIN_W-1]}}, cfg.gain_y}
                                          : UNITY_GAIN;
        s0_prodx_next = lx * gx_eff;
        s0_prody_next = ly * gy_eff;
        s0_aw_next    = (cfg.angle >= ANGLE_TURN) ? cfg.angle - ANGLE_TURN : cfg.angle;
    end

    // Stage 1: round half up, clamp to 40 bits; start the angle conversion
    always_comb
    begin
        rx  = (PW + 1)'(s0_prodx_reg) + HALF;
        ry  = (PW + 1)'(s0_prody_reg) + HALF;
        shx = rx >>> FRAC_BITS;
        shy = ry >>> FRAC_BITS;
        s1_scl_next.sat = 1'b0;
        if (shx > SMAX)
        begin
            s1_scl_next.sx  = SCALED_MAX;
            s1_scl_next.sat = 1'b1;
        end
        else if (shx < SMIN)
        begin
            s1_scl_next.sx  = SCALED_MIN;
            s1_scl_next.sat = 1'b1;
        end
        else
        begin
            s1_scl_next.sx = shx[SCALED_W-1:0];
        end
        if (shy > SMAX)
        begin
            s1_scl_next.sy  = SCALED_MAX;
            s1_scl_next.sat = 1'b1;
        end
        else if (shy < SMIN)
        begin
            s1_scl_next.sy  = SCALED_MIN;
            s1_scl_next.sat = 1'b1;
        end
        else
        begin
            s1_scl_next.sy = shy[SCALED_W-1:0];
        end
        s1_v_next    = V_W'(s0_aw_reg) * V_W'(ANG_V_MUL) + V_W'(ANG_V_ADD);
        s1_base_next = BANG_W'(s0_aw_reg) * BANG_W'(ANG_BASE_MUL);
    end

    // Stage 2: quotient estimate by reciprocal, low by at most one
    always_comb
    begin
        mq         = MQ_W'(s1_v_reg) * MQ_W'(ANG_RECIP);
        s2_q0_next = mq[MQ_W-1:ANG_RECIP_SHIFT];
    end

    // Stage 3: remainder check fixes the estimate
    always_comb
    begin
        rem       = s2_v_reg - V_W'(s2_q0_reg) * V_W'(ANG_DIV);
        s3_q_next = s2_q0_reg + Q_W'(rem >= V_W'(ANG_DIV));
    end

    // Stage 4: binary angle; left half plane folded by 180 degrees
    always_comb
    begin
        bsum  = s3_base_reg + BANG_W'(s3_q_reg);
        fold  = bsum[BANG_W-1] ^ bsum[BANG_W-2];
        bfold = {bsum[BANG_W-1] ^ fold, bsum[BANG_W-2:0]};
        s4_cell_next.scl  = s3_scl_reg;
        s4_cell_next.flip = fold;
        s4_cell_next.cx   = CORDIC_K;
        s4_cell_next.cy   = '0;
        s4_cell_next.cz   = signed'(bfold);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            s0_prodx_reg <= s0_prodx_next;
            s0_prody_reg <= s0_prody_next;
            s0_aw_reg    <= s0_aw_next;
        end
        if (go[1])
        begin
            s1_scl_reg  <= s1_scl_next;
            s1_v_reg    <= s1_v_next;
            s1_base_reg <= s1_base_next;
        end
        if (go[2])
        begin
            s2_scl_reg  <= s1_scl_reg;
            s2_v_reg    <= s1_v_reg;
            s2_base_reg <= s1_base_reg;
            s2_q0_reg   <= s2_q0_next;
        end
        if (go[3])
        begin
            s3_scl_reg  <= s2_scl_reg;
            s3_base_reg <= s2_base_reg;
            s3_q_reg    <= s3_q_next;
        end
        if (go[4])
        begin
            s4_cell_reg <= s4_cell_next;
        end
    end

    assign in_rdy   = go[0];
    assign out_vld  = vld_reg[NST-1];
    assign out_data = s4_cell_reg;

    // An accepted beat always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld && in_rdy) |=> vld_reg[0])
        else $error("accepted beat missing from first front stage");

endmodule

// ----- design/srt_cordic_cell.sv -----
// One rotation-mode CORDIC cell with its own beat register.
module srt_cordic_cell
    import srt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_vld,
    output logic  in_rdy,
    input  cell_t in_data,
    output logic  out_vld,
    input  logic  out_rdy,
    output cell_t out_data
);

    localparam logic signed [CORDIC_W-1:0] ATAN_STEP = atan_turn(IDX);

    logic                       load;
    logic                       vld_reg, vld_next;
    cell_t                      data_reg, data_next;
    logic signed [CORDIC_W-1:0] x, y, z;

    assign load = !vld_reg || out_rdy;

    // Micro-rotation: direction from the sign of the residual angle
    always_comb
    begin
        x = in_data.cx;
        y = in_data.cy;
        z = in_data.cz;
        data_next = in_data;
        if (!z[CORDIC_W-1])
        begin
            data_next.cx = x - (y >>> IDX);
            data_next.cy = y + (x >>> IDX);
            data_next.cz = z - ATAN_STEP;
        end
        else
        begin
            data_next.cx = x + (y >>> IDX);
            data_next.cy = y - (x >>> IDX);
            data_next.cz = z + ATAN_STEP;
        end
        vld_next = load ? in_vld : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign in_rdy   = load;
    assign out_vld  = vld_reg;
    assign out_data = data_reg;

    // A held beat is neither dropped nor changed
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !out_rdy) |=> vld_reg)
        else $error("cordic cell lost a held beat");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !out_rdy) |=> $stable(data_reg))
        else $error("cordic cell changed a held beat");

endmodule

// ----- design/srt_rotate.sv -----
// Back pipeline: sine/cosine rounding, split rotation products, offset and output saturation.
module srt_rotate
    import srt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_vld,
    output logic                      in_rdy,
    input  cell_t                     in_data,
    output logic                      out_vld,
    input  logic                      out_rdy,
    output logic signed [COORD_W-1:0] wx,
    output logic signed [COORD_W-1:0] wy,
    output logic                      sat
);

    localparam int NST      = 6;
    localparam int LO_W     = 16;
    localparam int HI_W     = SCALED_W - LO_W;
    localparam int HI_PP_W  = HI_W + TRIG_W;
    localparam int LO_PP_W  = LO_W + 1 + TRIG_W;
    localparam int PROD_W   = SCALED_W + TRIG_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int RND_W    = SUM_W - TRIG_FRAC;
    localparam logic signed [CORDIC_W:0] CORDIC_HALF = {{CORDIC_W{1'b0}}, 1'b1} << (TRIG_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]  SUM_HALF    = {{(SUM_W-1){1'b0}}, 1'b1} << (TRIG_FRAC - 1);
    localparam logic signed [RND_W:0]    WMAX        = (RND_W + 1)'(COORD_MAX);
    localparam logic signed [RND_W:0]    WMIN        = (RND_W + 1)'(COORD_MIN);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] go;

    // stage T
    logic signed [CORDIC_W:0]    tcx, tcy;
    logic signed [TRIG_W-1:0]    cr, sr;
    logic signed [TRIG_W-1:0]    t_c_reg, t_c_next;
    logic signed [TRIG_W-1:0]    t_s_reg, t_s_next;
    scl_t                        t_scl_reg;
    // stage R1
    logic signed [SCALED_W-1:0]  a_op [4];
    logic signed [TRIG_W-1:0]    b_op [4];
    logic signed [HI_W-1:0]      a_hi [4];
    logic signed [LO_W:0]        a_lo [4];
    logic signed [HI_PP_W-1:0]   hi_reg [4];
    logic signed [HI_PP_W-1:0]   hi_next [4];
    logic signed [LO_PP_W-1:0]   lo_reg [4];
    logic signed [LO_PP_W-1:0]   lo_next [4];
    logic                        r1_sat_reg;
    // stage R2
    logic signed [PROD_W-1:0]    full_reg [4];
    logic signed [PROD_W-1:0]    full_next [4];
    logic                        r2_sat_reg;
    // stage R3
    logic signed [SUM_W-1:0]     sumx_reg, sumx_next;
    logic signed [SUM_W-1:0]     sumy_reg, sumy_next;
    logic                        r3_sat_reg;
    // stage R4
    logic signed [SUM_W-1:0]     tx, ty;
    logic signed [RND_W-1:0]     rndx_reg, rndx_next;
    logic signed [RND_W-1:0]     rndy_reg, rndy_next;
    logic                        r4_sat_reg;
    // stage R5
    logic signed [COORD_W-1:0]   offx, offy;
    logic signed [RND_W:0]       ex, ey;
    logic signed [COORD_W-1:0]   wx_reg, wx_next;
    logic signed [COORD_W-1:0]   wy_reg, wy_next;
    logic                        sat_reg, sat_next;

    // Stall chain
    always_comb
    begin
        go[NST-1] = !vld_reg[NST-1] || out_rdy;
        for (int i = NST - 2; i >= 0; i--)
        begin
            go[i] = !vld_reg[i] || go[i+1];
        end
        vld_next[0] = go[0] ? in_vld : vld_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            vld_next[i] = go[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage T: cosine/sine to 22 fraction bits, undo the fold; pass mode is identity
    always_comb
    begin
        tcx = (CORDIC_W + 1)'(in_data.cx) + CORDIC_HALF;
        tcy = (CORDIC_W + 1)'(in_data.cy) + CORDIC_HALF;
        cr  = tcx[TRIG_W+TRIG_SHIFT-1:TRIG_SHIFT];
        sr  = tcy[TRIG_W+TRIG_SHIFT-1:TRIG_SHIFT];
        if (!cfg.parent_enable)
        begin
            t_c_next = TRIG_ONE;
            t_s_next = '0;
        end
        else if (in_data.flip)
        begin
            t_c_next = -cr;
            t_s_next = -sr;
        end
        else
        begin
            t_c_next = cr;
            t_s_next = sr;
        end
    end

    // Stage R1: each 40x24 product as high and low partial products
    always_comb
    begin
        a_op[0] = t_scl_reg.sx;  b_op[0] = t_c_reg;
        a_op[1] = t_scl_reg.sy;  b_op[1] = t_s_reg;
        a_op[2] = t_scl_reg.sx;  b_op[2] = t_s_reg;
        a_op[3] = t_scl_reg.sy;  b_op[3] = t_c_reg;
        for (int k = 0; k < 4; k++)
        begin
            a_hi[k]    = $signed(a_op[k][SCALED_W-1:LO_W]);
            a_lo[k]    = $signed({1'b0, a_op[k][LO_W-1:0]});
            hi_next[k] = a_hi[k] * b_op[k];
            lo_next[k] = a_lo[k] * b_op[k];
        end
    end

    // Stage R2: recombine partial products
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            full_next[k] = (PROD_W'(hi_reg[k]) <<< LO_W) + PROD_W'(lo_reg[k]);
        end
    end

    // Stage R3: rotation sums
    always_comb
    begin
        sumx_next = SUM_W'(full_reg[0]) - SUM_W'(full_reg[1]);
        sumy_next = SUM_W'(full_reg[2]) + SUM_W'(full_reg[3]);
    end

    // Stage R4: round half up by 22 bits
    always_comb
    begin
        tx        = sumx_reg + SUM_HALF;
        ty        = sumy_reg + SUM_HALF;
        rndx_next = tx[SUM_W-1:TRIG_FRAC];
        rndy_next = ty[SUM_W-1:TRIG_FRAC];
    end

    // Stage R5: translate, then saturate to 32 bits
    always_comb
    begin
        offx     = cfg.parent_enable ? cfg.offset_x : '0;
        offy     = cfg.parent_enable ? cfg.offset_y : '0;
        ex       = (RND_W + 1)'(rndx_reg) + (RND_W + 1)'(offx);
        ey       = (RND_W + 1)'(rndy_reg) + (RND_W + 1)'(offy);
        sat_next = r4_sat_reg;
        if (ex > WMAX)
        begin
            wx_next  = COORD_MAX;
            sat_next = 1'b1;
        end
        else if (ex < WMIN)
        begin
            wx_next  = COORD_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            wx_next = ex[COORD_W-1:0];
        end
        if (ey > WMAX)
        begin
            wy_next  = COORD_MAX;
            sat_next = 1'b1;
        end
        else if (ey < WMIN)
        begin
            wy_next  = COORD_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            wy_next = ey[COORD_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            t_c_reg   <= t_c_next;
            t_s_reg   <= t_s_next;
            t_scl_reg <= in_data.scl;
        end
        if (go[1])
        begin
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            r1_sat_reg <= t_scl_reg.sat;
        end
        if (go[2])
        begin
            full_reg   <= full_next;
            r2_sat_reg <= r1_sat_reg;
        end
        if (go[3])
        begin
            sumx_reg   <= sumx_next;
            sumy_reg   <= sumy_next;
            r3_sat_reg <= r2_sat_reg;
        end
        if (go[4])
        begin
            rndx_reg   <= rndx_next;
            rndy_reg   <= rndy_next;
            r4_sat_reg <= r3_sat_reg;
        end
        if (go[5])
        begin
            wx_reg  <= wx_next;
            wy_reg  <= wy_next;
            sat_reg <= sat_next;
        end
    end

    assign in_rdy  = go[0];
    assign out_vld = vld_reg[NST-1];
    assign wx      = wx_reg;
    assign wy      = wy_reg;
    assign sat     = sat_reg;

endmodule

// ----- design/scale_rotate_translate_2d_unit.sv -----
// Top level of the 2D scale, rotate and translate unit: configuration registers and the cell chain.
//
// Maps a local Q16.16 point to world coordinates: each axis is scaled by its own
// Q8.16 gain, the result is rotated counter-clockwise by the configured angle
// (1/128 degree units) and the parent offset is added; each coordinate saturates
// to the signed 32-bit range and `saturated` flags any clamp. With parent_enable
// clear the point passes through unchanged. The unit takes one point per clock
// while in_ready is high and passes each through five front stages (scaling and
// the angle conversion, including the fold by 180 degrees), one CORDIC cell per
// stage, and six back stages (sine/cosine rounding, split rotation products,
// sums, rounding, translation with saturation). Every stage has its own beat
// register, so in_ready drops only when all stages hold a beat and the output is
// stalled. Configuration writes take effect on the next cycle and are meant to
// happen while no point is in flight.
module scale_rotate_translate_2d_unit
    import srt_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    // input points
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   local_x,
    input  logic signed [COORD_W-1:0]   local_y,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_W-1:0]   world_x,
    output logic signed [COORD_W-1:0]   world_y,
    output logic                        saturated
);

    logic                      parent_enable_reg;
    logic signed [COORD_W-1:0] offset_x_reg;
    logic signed [COORD_W-1:0] offset_y_reg;
    logic [ANG_W-1:0]          angle_reg;
    logic signed [GAIN_W-1:0]  gain_x_reg;
    logic signed [GAIN_W-1:0]  gain_y_reg;
    cfg_t                      cfg;

    logic  cell_vld  [CORDIC_STAGES+1];
    logic  cell_rdy  [CORDIC_STAGES+1];
    cell_t cell_data [CORDIC_STAGES+1];

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parent_enable_reg <= 1'b0;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            angle_reg         <= '0;
            gain_x_reg        <= GAIN_ONE;
            gain_y_reg        <= GAIN_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PARENT_ENABLE: parent_enable_reg <= cfg_data[0];
                REG_OFFSET_X:      offset_x_reg      <= signed'(cfg_data[COORD_W-1:0]);
                REG_OFFSET_Y:      offset_y_reg      <= signed'(cfg_data[COORD_W-1:0]);
                REG_ANGLE:         angle_reg         <= cfg_data[ANG_W-1:0];
                REG_GAIN_X:        gain_x_reg        <= signed'(cfg_data[GAIN_W-1:0]);
                REG_GAIN_Y:        gain_y_reg        <= signed'(cfg_data[GAIN_W-1:0]);
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg.parent_enable = parent_enable_reg;
        cfg.offset_x      = offset_x_reg;
        cfg.offset_y      = offset_y_reg;
        cfg.angle         = angle_reg;
        cfg.gain_x        = gain_x_reg;
        cfg.gain_y        = gain_y_reg;
    end

    // Scaling and angle conversion
    srt_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_vld   (in_valid),
        .in_rdy   (in_ready),
        .lx       (local_x),
        .ly       (local_y),
        .out_vld  (cell_vld[0]),
        .out_rdy  (cell_rdy[0]),
        .out_data (cell_data[0])
    );

    // CORDIC cell chain
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        srt_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (cell_vld[i]),
            .in_rdy   (cell_rdy[i]),
            .in_data  (cell_data[i]),
            .out_vld  (cell_vld[i+1]),
            .out_rdy  (cell_rdy[i+1]),
            .out_data (cell_data[i+1])
        );
    end

    // Rotation, translation and saturation
    srt_rotate u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_vld   (cell_vld[CORDIC_STAGES]),
        .in_rdy   (cell_rdy[CORDIC_STAGES]),
        .in_data  (cell_data[CORDIC_STAGES]),
        .out_vld  (out_valid),
        .out_rdy  (out_ready),
        .wx       (world_x),
        .wy       (world_y),
        .sat      (saturated)
    );

    // Input back-pressure only when the whole chain is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the pipeline has room");

    // Writes to unknown indexes leave every register alone
    a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index > REG_GAIN_Y) |=>
        ($stable(parent_enable_reg) && $stable(offset_x_reg) && $stable(offset_y_reg)
         && $stable(angle_reg) && $stable(gain_x_reg) && $stable(gain_y_reg)))
        else $error("write to unknown register index changed state");

endmodule
